[hdl/lrs_pkg.sv]
// Shared types, codes and filter coefficient tables for the line resampler.
package lrs_pkg;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    // configuration register indexes
    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_TGT = 1'b1;

    // input item codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_in;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_out;
        logic       status;
    } t_out;

    typedef enum logic [1:0] {
        M_EVEN,
        M_ODD,
        M_INTERP
    } t_mode;

    // halving taps laid out over the eight reads starting at i-3
    localparam logic signed [7:0] EVEN_TAPS [8] = '{
        -8'sd1, -8'sd3, 8'sd12, 8'sd56, 8'sd56, 8'sd12, -8'sd3, -8'sd1};
    localparam logic signed [7:0] ODD_TAPS [8] = '{
        -8'sd3, 8'sd0, 8'sd35, 8'sd64, 8'sd35, 8'sd0, -8'sd3, 8'sd0};

    localparam logic signed [7:0] KERN [32][8] = '{
        '{-8'sd1, -8'sd8, 8'sd33, 8'sd80, 8'sd33, -8'sd8, -8'sd1, 8'sd0},
        '{-8'sd1, -8'sd8, 8'sd30, 8'sd80, 8'sd35, -8'sd8, -8'sd1, 8'sd1},
        '{-8'sd1, -8'sd8, 8'sd28, 8'sd80, 8'sd37, -8'sd7, -8'sd2, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd26, 8'sd79, 8'sd39, -8'sd7, -8'sd2, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd24, 8'sd79, 8'sd41, -8'sd7, -8'sd2, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd22, 8'sd78, 8'sd43, -8'sd6, -8'sd2, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd20, 8'sd78, 8'sd45, -8'sd5, -8'sd3, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd18, 8'sd77, 8'sd48, -8'sd5, -8'sd3, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd16, 8'sd76, 8'sd50, -8'sd4, -8'sd3, 8'sd1},
        '{8'sd0, -8'sd8, 8'sd15, 8'sd75, 8'sd52, -8'sd3, -8'sd4, 8'sd1},
        '{8'sd0, -8'sd7, 8'sd13, 8'sd74, 8'sd54, -8'sd3, -8'sd4, 8'sd1},
        '{8'sd0, -8'sd7, 8'sd11, 8'sd73, 8'sd56, -8'sd2, -8'sd4, 8'sd1},
        '{8'sd0, -8'sd7, 8'sd10, 8'sd71, 8'sd58, -8'sd1, -8'sd4, 8'sd1},
        '{8'sd1, -8'sd7, 8'sd8, 8'sd70, 8'sd60, 8'sd0, -8'sd5, 8'sd1},
        '{8'sd1, -8'sd6, 8'sd6, 8'sd68, 8'sd62, 8'sd1, -8'sd5, 8'sd1},
        '{8'sd1, -8'sd6, 8'sd5, 8'sd67, 8'sd63, 8'sd2, -8'sd5, 8'sd1},
        '{8'sd1, -8'sd6, 8'sd4, 8'sd65, 8'sd65, 8'sd4, -8'sd6, 8'sd1},
        '{8'sd1, -8'sd5, 8'sd2, 8'sd63, 8'sd67, 8'sd5, -8'sd6, 8'sd1},
        '{8'sd1, -8'sd5, 8'sd1, 8'sd62, 8'sd68, 8'sd6, -8'sd6, 8'sd1},
        '{8'sd1, -8'sd5, 8'sd0, 8'sd60, 8'sd70, 8'sd8, -8'sd7, 8'sd1},
        '{8'sd1, -8'sd4, -8'sd1, 8'sd58, 8'sd71, 8'sd10, -8'sd7, 8'sd0},
        '{8'sd1, -8'sd4, -8'sd2, 8'sd56, 8'sd73, 8'sd11, -8'sd7, 8'sd0},
        '{8'sd1, -8'sd4, -8'sd3, 8'sd54, 8'sd74, 8'sd13, -8'sd7, 8'sd0},
        '{8'sd1, -8'sd4, -8'sd3, 8'sd52, 8'sd75, 8'sd15, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd3, -8'sd4, 8'sd50, 8'sd76, 8'sd16, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd3, -8'sd5, 8'sd48, 8'sd77, 8'sd18, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd3, -8'sd5, 8'sd45, 8'sd78, 8'sd20, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd2, -8'sd6, 8'sd43, 8'sd78, 8'sd22, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd2, -8'sd7, 8'sd41, 8'sd79, 8'sd24, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd2, -8'sd7, 8'sd39, 8'sd79, 8'sd26, -8'sd8, 8'sd0},
        '{8'sd1, -8'sd2, -8'sd7, 8'sd37, 8'sd80, 8'sd28, -8'sd8, -8'sd1},
        '{8'sd1, -8'sd1, -8'sd8, 8'sd35, 8'sd80, 8'sd30, -8'sd8, -8'sd1}
    };

    function automatic logic signed [7:0] lrs_coef(input t_mode m, input logic [4:0] sub,
                                                   input logic [2:0] k);
        logic signed [7:0] c;
        case (m)
            M_EVEN:   c = EVEN_TAPS[k];
            M_ODD:    c = ODD_TAPS[k];
            M_INTERP: c = KERN[sub][k];
            default:  c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

[hdl/line_resampler_8tap.sv]
// Top level: configuration registers, command queue, back end and result queue.
// A load beat is taken as soon as it reaches the back end.
// A read beat on a copy passes S_PIX and S_CPW; with interpolation it passes S_PIX, the MAC
// loop for the 8 taps behind a registered store read, and S_FIN. The first read of a line also
// runs the halving passes and two divisions of LW+32 quotient bits each
// (LW = clog2(MAX_LINE+1)). Synchronous active-low reset; a register write restarts the line.
module line_resampler_8tap #(
    parameter int MAX_LINE = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    input  lrs_pkg::t_in             i_data,
    output logic                     full,
    output logic                     empty,
    input  logic                     pop,
    output lrs_pkg::t_out            o_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [lrs_pkg::CFG_W-1:0] i_cfg_data
);
    import lrs_pkg::*;

    localparam int LW = $clog2(MAX_LINE + 1);

    logic [CFG_W-1:0]     r_src_cfg;
    logic [CFG_W-1:0]     r_tgt_cfg;
    logic [LW-1:0]        src_len;
    logic [LW-1:0]        tgt_len;
    logic                 cmd_empty;
    logic                 cmd_pop;
    logic [$bits(t_in)-1:0]  cmd_data;
    logic                 res_full;
    logic                 res_push;
    t_out                 res_data;
    logic [$bits(t_out)-1:0] res_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_cfg <= CFG_RESET;
            r_tgt_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC: r_src_cfg <= i_cfg_data;
                CFG_TGT: r_tgt_cfg <= i_cfg_data;
                default: r_src_cfg <= r_src_cfg;
            endcase
        end
    end

    // zero acts as one, anything past the store depth as the depth
    always_comb begin
        if (r_src_cfg == '0) begin
            src_len = LW'(1);
        end else if (32'(r_src_cfg) > MAX_LINE) begin
            src_len = LW'(MAX_LINE);
        end else begin
            src_len = LW'(r_src_cfg);
        end
        if (r_tgt_cfg == '0) begin
            tgt_len = LW'(1);
        end else if (32'(r_tgt_cfg) > MAX_LINE) begin
            tgt_len = LW'(MAX_LINE);
        end else begin
            tgt_len = LW'(r_tgt_cfg);
        end
    end

    lrs_queue #(
        .W ($bits(t_in))
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data),
        .o_full  (full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (cmd_data)
    );

    lrs_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_src_len   (src_len),
        .i_tgt_len   (tgt_len),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (t_in'(cmd_data)),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_data)
    );

    lrs_queue #(
        .W ($bits(t_out))
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (res_q)
    );

    assign o_data = t_out'(res_q);

endmodule

[hdl/lrs_queue.sv]
// Two-entry queue used on the command side and on the result side.
module lrs_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push_ok;
    logic         pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/lrs_div.sv]
// Restoring divider, one quotient bit per cycle, for the phase step and offset.
module lrs_div #(
    parameter int NW = 45,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_q;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_nx;
    logic          ge;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign ge     = (rem_sh >= {1'b0, i_den});
    assign rem_nx = ge ? (rem_sh - {1'b0, i_den}) : rem_sh;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[NW-2:0], ge};
                r_rem <= rem_nx[DW-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/lrs_core.sv]
// Back end: line stores, halving passes, phase setup, 8-tap interpolation and plain copy.
module lrs_core #(
    parameter int MAX_LINE = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [$clog2(MAX_LINE+1)-1:0]  i_src_len,
    input  logic [$clog2(MAX_LINE+1)-1:0]  i_tgt_len,
    input  logic                           i_cmd_valid,
    input  lrs_pkg::t_in                   i_cmd,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output lrs_pkg::t_out                  o_res
);
    import lrs_pkg::*;

    localparam int AW    = $clog2(MAX_LINE);
    localparam int LW    = $clog2(MAX_LINE + 1);
    localparam int XW    = LW + 2;
    localparam int NW    = LW + 32;
    localparam int PW    = NW + 1;
    localparam int ACC_W = 20;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(64);
    localparam logic signed [XW-1:0]    TAP_BACK = XW'(3);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PCHK,
        S_MAC,
        S_FIN,
        S_DIV1,
        S_DIV1W,
        S_DIV2,
        S_DIV2W,
        S_PIX,
        S_CPW
    } t_state;

    t_state                  r_state;
    logic [LW-1:0]           r_loaded;
    logic [LW-1:0]           r_oidx;
    logic                    r_prep;
    logic [LW-1:0]           r_len;
    logic                    r_sel;
    logic [AW-1:0]           r_o;
    t_mode                   r_mode;
    logic [4:0]              r_sub;
    logic [3:0]              r_k;
    logic signed [XW-1:0]    r_base;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PW-1:0]    r_pos;
    logic signed [PW-1:0]    r_step;
    logic                    r_push;
    t_out                    r_res;

    logic [7:0]              r_line [MAX_LINE];
    logic [7:0]              r_scr  [MAX_LINE];
    logic [7:0]              r_line_rd;
    logic [7:0]              r_scr_rd;

    logic signed [XW-1:0]    idx;
    logic [AW-1:0]           clamp_addr;
    logic [AW-1:0]           rd_addr;
    logic [LW-1:0]           len_dec;
    logic [LW:0]             half_full;
    logic [LW-1:0]           half;
    logic [LW-1:0]           o_next;
    logic [7:0]              rd_data;
    logic signed [7:0]       coef;
    logic signed [16:0]      prod;
    logic [7:0]              clip;
    logic [LW:0]             oidx_inc;
    logic                    last;
    logic                    line_we;
    logic                    scr_we;
    logic [AW-1:0]           wr_addr;
    logic [7:0]              wr_data;
    logic [LW:0]             int_pel;
    logic [LW-1:0]           diff;
    logic                    div_start;
    logic [NW-1:0]           div_num;
    logic                    div_done;
    logic [NW-1:0]           div_quot;
    logic                    halve_go;
    logic                    fin_halve;

    assign len_dec   = r_len - LW'(1);
    assign half_full = ({1'b0, r_len} + (LW+1)'(1)) >> 1;
    assign half      = half_full[LW-1:0];
    assign o_next    = LW'(r_o) + LW'(1);
    assign rd_data   = r_sel ? r_scr_rd : r_line_rd;
    assign coef      = lrs_coef(r_mode, r_sub, 3'(r_k - 4'd1));
    assign prod      = coef * $signed({1'b0, rd_data});
    assign oidx_inc  = {1'b0, r_oidx} + (LW+1)'(1);
    assign last      = (oidx_inc >= {1'b0, i_tgt_len});
    assign int_pel   = r_pos[PW-1:32];
    assign diff      = (r_len > i_tgt_len) ? (r_len - i_tgt_len) : (i_tgt_len - r_len);
    assign halve_go  = (i_src_len != i_tgt_len) && (r_len > LW'(1)) && (half >= i_tgt_len);
    assign fin_halve = (r_state == S_FIN) && (r_mode != M_INTERP);

    // clamp the tap index to the current line
    always_comb begin
        idx = r_base + $signed(XW'(r_k));
        if (idx[XW-1]) begin
            clamp_addr = '0;
        end else if (idx >= $signed({2'b00, r_len})) begin
            clamp_addr = len_dec[AW-1:0];
        end else begin
            clamp_addr = idx[AW-1:0];
        end
        rd_addr = (r_state == S_PIX) ? r_oidx[AW-1:0] : clamp_addr;
    end

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            clip = 8'd0;
        end else if (|r_acc[ACC_W-2:15]) begin
            clip = 8'hFF;
        end else begin
            clip = r_acc[14:7];
        end
    end

    // loads fill the line store; a halving pass writes the store it does not read
    always_comb begin
        line_we = 1'b0;
        scr_we  = 1'b0;
        wr_addr = r_o;
        wr_data = clip;
        if (r_state == S_IDLE) begin
            line_we = i_cmd_valid && (i_cmd.func == FUNC_LOAD) && (r_loaded < i_src_len);
            wr_addr = r_loaded[AW-1:0];
            wr_data = i_cmd.pixel_in;
        end else if (fin_halve) begin
            line_we = r_sel;
            scr_we  = !r_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            r_line[wr_addr] <= wr_data;
        end
        r_line_rd <= r_line[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr[wr_addr] <= wr_data;
        end
        r_scr_rd <= r_scr[rd_addr];
    end

    always_comb begin
        div_start = (r_state == S_DIV1) || (r_state == S_DIV2);
        if (r_state == S_DIV1) begin
            div_num = {r_len, 32'd0} + NW'(i_tgt_len >> 1);
        end else begin
            div_num = NW'({diff, 31'd0}) + NW'(i_tgt_len >> 1);
        end
    end

    lrs_div #(
        .NW (NW),
        .DW (LW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (i_tgt_len),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // hold a read while the result queue is full or a result beat is still on its way into it
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid &&
                        ((i_cmd.func == FUNC_LOAD) || (!i_res_full && !r_push));
    assign o_res_push = r_push;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loaded <= '0;
            r_oidx   <= '0;
            r_prep   <= 1'b0;
            r_push   <= 1'b0;
        end else if (i_restart) begin
            r_loaded <= '0;
            r_oidx   <= '0;
            r_prep   <= 1'b0;
            r_push   <= 1'b0;
        end else begin
            r_push <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.func == FUNC_LOAD) begin
                            if (r_loaded < i_src_len) begin
                                r_loaded <= r_loaded + LW'(1);
                            end
                        end else if (r_loaded < i_src_len) begin
                            r_push <= 1'b1;
                            r_res  <= '{pixel_out: 8'd0, last_out: 1'b0, status: 1'b1};
                        end else if (r_prep) begin
                            r_state <= S_PIX;
                        end else begin
                            r_len   <= i_src_len;
                            r_sel   <= 1'b0;
                            r_state <= S_PCHK;
                        end
                    end
                end
                S_PCHK: begin
                    if (halve_go) begin
                        r_o     <= '0;
                        r_mode  <= r_len[0] ? M_ODD : M_EVEN;
                        r_base  <= -TAP_BACK;
                        r_k     <= 4'd0;
                        r_acc   <= RND;
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_MAC: begin
                    if (r_k != 4'd0) begin
                        r_acc <= r_acc + ACC_W'(prod);
                    end
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd8) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_mode == M_INTERP) begin
                        r_pos   <= r_pos + r_step;
                        r_push  <= 1'b1;
                        r_res   <= '{pixel_out: clip, last_out: last, status: 1'b0};
                        r_oidx  <= last ? '0 : oidx_inc[LW-1:0];
                        if (last) begin
                            r_loaded <= '0;
                            r_prep   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end else if (o_next == half) begin
                        // pass done: the halved line now lives in the other store
                        r_len   <= half;
                        r_sel   <= ~r_sel;
                        r_state <= S_PCHK;
                    end else begin
                        r_o     <= o_next[AW-1:0];
                        r_base  <= $signed(XW'({o_next, 1'b0})) - TAP_BACK;
                        r_k     <= 4'd0;
                        r_acc   <= RND;
                        r_state <= S_MAC;
                    end
                end
                S_DIV1: begin
                    r_state <= S_DIV1W;
                end
                S_DIV1W: begin
                    if (div_done) begin
                        r_step  <= $signed({1'b0, div_quot});
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    r_state <= S_DIV2W;
                end
                S_DIV2W: begin
                    if (div_done) begin
                        if (r_len > i_tgt_len) begin
                            r_pos <= $signed({1'b0, div_quot});
                        end else begin
                            r_pos <= -$signed({1'b0, div_quot});
                        end
                        r_prep  <= 1'b1;
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (r_len == i_tgt_len) begin
                        r_state <= S_CPW;
                    end else begin
                        r_mode  <= M_INTERP;
                        r_sub   <= r_pos[31:27];
                        r_base  <= $signed({int_pel[LW], int_pel}) - TAP_BACK;
                        r_k     <= 4'd0;
                        r_acc   <= RND;
                        r_state <= S_MAC;
                    end
                end
                S_CPW: begin
                    r_push <= 1'b1;
                    r_res  <= '{pixel_out: rd_data, last_out: last, status: 1'b0};
                    r_oidx <= last ? '0 : oidx_inc[LW-1:0];
                    if (last) begin
                        r_loaded <= '0;
                        r_prep   <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
